/* src/rgbblur_pkg.sv */
// ============================================================================
// rgbblur_pkg
// Shared types, constants and helpers for the 3x3 RGB Gaussian blur block.
// ============================================================================
package rgbblur_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 4096;

    localparam int unsigned IMG_WIDTH_W  = 12;
    localparam int unsigned IMG_HEIGHT_W = 13;
    localparam int unsigned CFG_IDX_W    = 8;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = CFG_IDX_W'(1);

    localparam int unsigned RESET_IMG_WIDTH  = 640;
    localparam int unsigned RESET_IMG_HEIGHT = 480;

    localparam int unsigned MIN_DIM = 3;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] pix_r;
        logic [7:0] pix_g;
        logic [7:0] pix_b;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
        logic       frame_end;
    } t_pix_out;

    // One full neighborhood: px[column][row], column 0 is leftmost, row 0 is top.
    typedef struct packed {
        t_pix_in [2:0][2:0] px;
        logic               frame_end;
    } t_win;

    // Last valid index of a dimension after clamping it into [MIN_DIM, maxv].
    function automatic int unsigned dim_last(input int unsigned v, input int unsigned maxv);
        int unsigned eff;
        eff = v;
        if (v < MIN_DIM) begin
            eff = MIN_DIM;
        end else if (v > maxv) begin
            eff = maxv;
        end
        return eff - 1;
    endfunction

endpackage

/* src/rgbblur_front.sv */
// ============================================================================
// rgbblur_front
// Pixel intake: position counters, line stores and the sliding window columns.
// ============================================================================
module rgbblur_front
    import rgbblur_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_pix_in               i_pix,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_win_valid,
    input  logic                  i_win_ready,
    output t_win                  o_win
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] r_w_last;
    logic [RW-1:0] r_h_last;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    t_pix_in r_line_upper [MAX_WIDTH];
    t_pix_in r_line_lower [MAX_WIDTH];
    t_pix_in r_top;
    t_pix_in r_mid;

    logic          r_s1_valid;
    t_pix_in       r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_emit;
    logic          r_s1_fend;

    t_pix_in [2:0] r_win_c0;
    t_pix_in [2:0] r_win_c1;

    logic cfg_hit;
    logic accept;
    logic advance;

    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == REG_IMG_WIDTH || i_cfg_index == REG_IMG_HEIGHT);
    assign advance = r_s1_valid && (!r_s1_emit || i_win_ready);
    assign o_ready = !r_s1_valid || advance;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(dim_last(RESET_IMG_WIDTH, MAX_WIDTH));
            r_h_last <= RW'(dim_last(RESET_IMG_HEIGHT, MAX_HEIGHT));
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_IMG_WIDTH) begin
                r_w_last <= CW'(dim_last(32'(i_cfg_data[IMG_WIDTH_W-1:0]), MAX_WIDTH));
            end
            if (i_cfg_index == REG_IMG_HEIGHT) begin
                r_h_last <= RW'(dim_last(32'(i_cfg_data[IMG_HEIGHT_W-1:0]), MAX_HEIGHT));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col == r_w_last) begin
                r_col <= '0;
                r_row <= (r_row == r_h_last) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Line store reads happen as a pixel is taken; the writes follow when it leaves.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top <= r_line_upper[r_col];
            r_mid <= r_line_lower[r_col];
        end
        if (advance) begin
            r_line_upper[r_s1_col] <= r_mid;
            r_line_lower[r_s1_col] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= i_pix;
            r_s1_col  <= r_col;
            r_s1_emit <= (r_row >= RW'(2)) && (r_col >= CW'(2));
            r_s1_fend <= (r_row == r_h_last) && (r_col == r_w_last);
        end
        if (advance) begin
            r_win_c0    <= r_win_c1;
            r_win_c1[0] <= r_top;
            r_win_c1[1] <= r_mid;
            r_win_c1[2] <= r_s1_pix;
        end
    end

    assign o_win_valid     = r_s1_valid && r_s1_emit;
    assign o_win.px[0]     = r_win_c0;
    assign o_win.px[1]     = r_win_c1;
    assign o_win.px[2][0]  = r_top;
    assign o_win.px[2][1]  = r_mid;
    assign o_win.px[2][2]  = r_s1_pix;
    assign o_win.frame_end = r_s1_fend;

endmodule

/* src/rgbblur_queue.sv */
// ============================================================================
// rgbblur_queue
// Short FIFO of windows between the intake and the filter datapath.
// ============================================================================
module rgbblur_queue
    import rgbblur_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_win i_win,
    output logic o_valid,
    input  logic i_ready,
    output t_win o_win
);

    t_win                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    logic push;
    logic pop;

    assign o_ready = (r_count < (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_win   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QUEUE_PTR_W + 1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QUEUE_PTR_W + 1)'(1);
            end
        end
    end

endmodule

/* src/rgbblur_back.sv */
// ============================================================================
// rgbblur_back
// Kernel datapath: weights the window per channel, divides by 16, registers it.
// ============================================================================
module rgbblur_back
    import rgbblur_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_win     i_win,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pix_out o_pix
);

    logic     r_out_valid;
    t_pix_out r_out;
    t_pix_out n_out;

    logic [2:0][2:0][7:0] ch_r;
    logic [2:0][2:0][7:0] ch_g;
    logic [2:0][2:0][7:0] ch_b;

    logic pop;

    // 1-2-1 / 2-4-2 / 1-2-1 weighted sum, truncated by 16.
    function automatic logic [7:0] blur3(input logic [2:0][2:0][7:0] p);
        logic [11:0] s;
        s = {4'b0, p[0][0]} + {3'b0, p[1][0], 1'b0} + {4'b0, p[2][0]}
          + {3'b0, p[0][1], 1'b0} + {2'b0, p[1][1], 2'b0} + {3'b0, p[2][1], 1'b0}
          + {4'b0, p[0][2]} + {3'b0, p[1][2], 1'b0} + {4'b0, p[2][2]};
        return s[11:4];
    endfunction

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                ch_r[c][r] = i_win.px[c][r].pix_r;
                ch_g[c][r] = i_win.px[c][r].pix_g;
                ch_b[c][r] = i_win.px[c][r].pix_b;
            end
        end
        n_out.out_r     = blur3(ch_r);
        n_out.out_g     = blur3(ch_g);
        n_out.out_b     = blur3(ch_b);
        n_out.frame_end = i_win.frame_end;
    end

    assign o_ready = !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

endmodule

/* src/rgb_gaussian_blur_3x3_unit.sv */
// ============================================================================
// rgb_gaussian_blur_3x3_unit
// 3x3 Gaussian blur (1-2-1 kernel, divide by 16) of a raster RGB pixel stream.
// ============================================================================
// Throughput: one pixel word per clock, sustained, while the output is taken.
// Path: the edge that accepts the bottom-right pixel of a window loads the
// intake stage; the window then moves into the queue and from there into the
// filter output register, which presents its result word.
// Reset: synchronous, active low; clears counters, handshakes and the queue and
// loads the default frame size of 640 x 480. The line stores are not cleared:
// every entry is written in a frame's first rows before a window uses it.
// ============================================================================
//
// Structure
//   The front part takes each pixel word, tracks its column and row, reads the
//   two line stores (one and two rows up) at that column and shifts the 3x3
//   window. It decides whether the pixel completes a window that lies fully
//   inside the frame and whether that window is the frame's last one. Such
//   windows go into a two-entry queue. The back part pops a window, computes
//   the weighted sum of each channel and holds the result in an output
//   register, so the intake runs on while a word waits, until the queue fills.
//
// Configuration
//   Register 0 is the image width, register 1 the image height. Values below 3
//   act as 3; a width above the line store size or a height above MAX_HEIGHT
//   acts as that limit. A write to either register restarts the frame at the
//   next pixel. Writes are always taken; other indexes are ignored.
//
module rgb_gaussian_blur_3x3_unit
    import rgbblur_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_pix_in               i_pix,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_pix_out              o_pix,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic fq_valid;
    logic fq_ready;
    t_win fq_win;
    logic qb_valid;
    logic qb_ready;
    t_win qb_win;

    // Configuration writes need no wait state.
    assign o_cfg_ready = 1'b1;

    rgbblur_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pix       (i_pix),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_win_valid (fq_valid),
        .i_win_ready (fq_ready),
        .o_win       (fq_win)
    );

    rgbblur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_win   (fq_win),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_win   (qb_win)
    );

    rgbblur_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (qb_valid),
        .o_ready (qb_ready),
        .i_win   (qb_win),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (o_pix)
    );

endmodule

/* tb/blur_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// blur_checker
// Watches the pixel, result and register channels of the blur unit. It keeps
// its own line stores, window and frame position, works out the blurred word
// that each accepted pixel should produce, if any, and compares every
// result word field by field, in order.
// ============================================================================
module blur_checker
    import rgbblur_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  t_pix_in               i_pix,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  t_pix_out              i_res,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_done,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_words,
    output int                    o_frames
);

    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    t_pix_in                 line_two_up [DEF_MAX_WIDTH];
    t_pix_in                 line_one_up [DEF_MAX_WIDTH];
    // Entries 0..2 hold the column two back (top to bottom), 3..5 the column one back.
    t_pix_in                 left_cols [6];
    int unsigned             col_pos;
    int unsigned             row_pos;
    t_pix_out                blur_expected [$];
    bit                      leftover_checked = 1'b0;
    int                      mismatch_count   = 0;
    int                      pending_now      = 0;
    int                      words_seen       = 0;
    int                      frames_seen      = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_now;
    assign o_words   = words_seen;
    assign o_frames  = frames_seen;

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned top);
        if (raw < MIN_DIM) begin
            return MIN_DIM;
        end
        return (raw > top) ? top : raw;
    endfunction

    // Weighted 1-2-1 / 2-4-2 / 1-2-1 sum of one channel, row-major, truncated by 16.
    function automatic logic [7:0] kernel_avg(input logic [8:0][7:0] n);
        int unsigned sum;
        sum = n[0] + 2 * n[1] + n[2]
            + 2 * n[3] + 4 * n[4] + 2 * n[5]
            + n[6] + 2 * n[7] + n[8];
        return 8'(sum / 16);
    endfunction

    function automatic t_pix_out blur_window(input t_pix_in [8:0] nb, input logic last);
        t_pix_out        res;
        logic [8:0][7:0] red;
        logic [8:0][7:0] green;
        logic [8:0][7:0] blue;
        int              k;
        for (k = 0; k < 9; k++) begin
            red[k]   = nb[k].pix_r;
            green[k] = nb[k].pix_g;
            blue[k]  = nb[k].pix_b;
        end
        res.out_r     = kernel_avg(red);
        res.out_g     = kernel_avg(green);
        res.out_b     = kernel_avg(blue);
        res.frame_end = last;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pix_in       top_px;
        t_pix_in       mid_px;
        t_pix_in [8:0] nb;
        t_pix_out      want;
        int unsigned   w_eff;
        int unsigned   h_eff;
        if (!i_rst_n) begin
            width_reg  = IMG_WIDTH_W'(RESET_IMG_WIDTH);
            height_reg = IMG_HEIGHT_W'(RESET_IMG_HEIGHT);
            col_pos    = 0;
            row_pos    = 0;
            blur_expected.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (blur_expected.size() == 0) begin
                    report($sformatf("result word %h arrived with nothing expected", i_res));
                end else begin
                    want = blur_expected.pop_front();
                    if (i_res.out_r !== want.out_r) begin
                        report($sformatf("out_r got %0d expected %0d", i_res.out_r, want.out_r));
                    end
                    if (i_res.out_g !== want.out_g) begin
                        report($sformatf("out_g got %0d expected %0d", i_res.out_g, want.out_g));
                    end
                    if (i_res.out_b !== want.out_b) begin
                        report($sformatf("out_b got %0d expected %0d", i_res.out_b, want.out_b));
                    end
                    if (i_res.frame_end !== want.frame_end) begin
                        report($sformatf("frame_end got %b expected %b",
                                         i_res.frame_end, want.frame_end));
                    end
                    words_seen++;
                    if (want.frame_end) begin
                        frames_seen++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMG_WIDTH: begin
                        width_reg = i_cfg_data[IMG_WIDTH_W-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_IMG_HEIGHT: begin
                        height_reg = i_cfg_data[IMG_HEIGHT_W-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_pix_valid && i_pix_ready) begin
                w_eff  = clamp_size(width_reg, DEF_MAX_WIDTH);
                h_eff  = clamp_size(height_reg, DEF_MAX_HEIGHT);
                top_px = line_two_up[col_pos];
                mid_px = line_one_up[col_pos];
                if (row_pos >= 2 && col_pos >= 2) begin
                    nb = {i_pix, left_cols[5], left_cols[2],
                          mid_px, left_cols[4], left_cols[1],
                          top_px, left_cols[3], left_cols[0]};
                    want = blur_window(nb, row_pos == h_eff - 1 && col_pos == w_eff - 1);
                    blur_expected = {blur_expected, want};
                end
                left_cols[0] = left_cols[3];
                left_cols[1] = left_cols[4];
                left_cols[2] = left_cols[5];
                left_cols[3] = top_px;
                left_cols[4] = mid_px;
                left_cols[5] = i_pix;
                line_two_up[col_pos] = mid_px;
                line_one_up[col_pos] = i_pix;
                col_pos++;
                if (col_pos >= w_eff) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= h_eff) begin
                        row_pos = 0;
                    end
                end
            end

            if (i_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (blur_expected.size() != 0) begin
                    report($sformatf("%0d result words never arrived", blur_expected.size()));
                end
            end
        end
        pending_now = blur_expected.size();
    end

endmodule

/* tb/tb_rgb_gaussian_blur_3x3_unit.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_rgb_gaussian_blur_3x3_unit
// Stimulus and verdict for the 3x3 RGB Gaussian blur unit. Pixel words are
// streamed in raster order through frames of many sizes, with sizes written
// below the minimum, at the limits and beyond them, with random gaps on both
// handshakes and one long output stall. A checker module beside the block
// predicts every blurred word and counts mismatches.
// ============================================================================
module tb_rgb_gaussian_blur_3x3_unit
    import rgbblur_pkg::*;
();

    // The block presents a result once the pixel completing its window has
    // passed the intake stage, the queue and the output register. Pixels that
    // complete no window leave nothing to wait for, so a drain wait is let
    // pass before any register write or the verdict.
    localparam int DRAIN_CYCLES  = 8;
    // Length of the one long stretch during which the output is not taken.
    localparam int HOLD_CYCLES   = 300;
    // Pixel words in the stalled and randomized frames, at the least.
    localparam int RANDOM_PIXELS = 300;
    // The slowest correct run (under a thousand pixels, every one waiting the
    // longest gap on both sides, plus the long stall) stays within this limit.
    localparam int CYCLE_LIMIT   = 200_000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  s_valid     = 1'b0;
    t_pix_in               s_pix       = '0;
    logic                  dut_in_ready;
    logic                  dut_out_valid;
    t_pix_out              dut_out;
    logic                  rx_ready    = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  dut_cfg_ready;
    logic                  run_done    = 1'b0;

    int errors;
    int pending;
    int words;
    int frames;

    // When set, both sides run without idle cycles.
    bit burst       = 1'b0;
    bit rx_hold     = 1'b0;
    bit hold_go     = 1'b0;
    bit word_taken  = 1'b0;
    int rx_wait     = 0;
    int cycle_count = 0;
    int pixels_sent = 0;
    int reg_writes  = 0;
    int cur_w       = RESET_IMG_WIDTH;
    int cur_h       = RESET_IMG_HEIGHT;

    rgb_gaussian_blur_3x3_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (s_valid),
        .o_ready     (dut_in_ready),
        .i_pix       (s_pix),
        .o_valid     (dut_out_valid),
        .i_ready     (rx_ready),
        .o_pix       (dut_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (dut_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    blur_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix_valid (s_valid),
        .i_pix_ready (dut_in_ready),
        .i_pix       (s_pix),
        .i_res_valid (dut_out_valid),
        .i_res_ready (rx_ready),
        .i_res       (dut_out),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (dut_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_done      (run_done),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_words     (words),
        .o_frames    (frames)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d result words outstanding.",
                     cycle_count, pending);
            $display("[rgb_gaussian_blur_3x3_unit] ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // Random channels, with the two extremes drawn more often than chance gives.
    function automatic t_pix_in random_pixel();
        t_pix_in p;
        p = t_pix_in'($urandom);
        case ($urandom_range(0, 7))
            0: p.pix_r = '0;
            1: p.pix_r = '1;
            default: begin
            end
        endcase
        case ($urandom_range(0, 7))
            0: p.pix_g = '0;
            1: p.pix_g = '1;
            default: begin
            end
        endcase
        case ($urandom_range(0, 7))
            0: p.pix_b = '0;
            1: p.pix_b = '1;
            default: begin
            end
        endcase
        return p;
    endfunction

    // Output side. After each word taken it draws an idle count and keeps
    // ready low while counting it down. The long hold overrides everything.
    always @(posedge clk) begin
        word_taken <= dut_out_valid && rx_ready;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (word_taken) begin
                rx_wait = draw_gap();
            end
            if (rx_hold) begin
                rx_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    // The long output stall. It is timed in its own process while the
    // sender keeps offering pixels, so the block's queue fills and the
    // input side has to back off.
    initial begin
        wait (hold_go);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Offers one pixel word after its idle gap and returns at the edge that
    // accepts it. With no gap, valid simply stays high for the next word.
    task automatic send_pixel(input t_pix_in p);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_pix   <= p;
        do @(posedge clk); while (!dut_in_ready);
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Brings the block to rest: input idle, every expected word received,
    // and the pipeline given time to empty of pixels that produce nothing.
    task automatic settle();
        @(negedge clk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!dut_cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    initial begin : stimulus
        int                    k;
        int                    w_raw;
        int                    h_raw;
        int                    total;
        int                    split;
        int                    random_sent;
        bit                    wrote;
        logic [CFG_IDX_W-1:0]  junk_idx;
        logic [CFG_DATA_W-1:0] wr_data;

        random_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The frame size out of reset is 640 x 480. A short stretch stays
        // inside the first row, so no window may complete.
        burst = 1'b1;
        send_random(40);
        settle();

        // Smallest frame, given as width 0 and height 2, both of which act
        // as 3. A saturated frame gives the largest possible sum.
        burst = 1'b0;
        write_reg(REG_IMG_WIDTH, 16'd0);
        write_reg(REG_IMG_HEIGHT, 16'd2);
        cur_w = MIN_DIM;
        cur_h = MIN_DIM;
        repeat (9) send_pixel('1);

        // A second frame with no new setting: the position wraps by itself.
        // Neighbors alternate between opposite extremes on every channel.
        for (k = 0; k < 9; k++) begin
            send_pixel((k % 2 == 0) ? t_pix_in'({8'hFF, 8'h00, 8'hFF})
                                    : t_pix_in'({8'h00, 8'hFF, 8'h00}));
        end
        settle();

        // A write to an unused register index in the middle of a frame must
        // leave the frame position alone.
        write_reg(REG_IMG_WIDTH, 16'd4);
        write_reg(REG_IMG_HEIGHT, 16'd1);
        cur_w = 4;
        send_random(5);
        settle();
        write_reg('1, '1);
        send_random(7);
        settle();

        // Widest setting: 4095 in the register acts as the line store size.
        // Upper data bits beyond the register width are set and dropped. The
        // first row is far from closing, so no window may complete.
        burst = 1'b1;
        write_reg(REG_IMG_WIDTH, 16'hFFFF);
        write_reg(REG_IMG_HEIGHT, 16'd3);
        send_random(40);
        settle();

        // The exact upper limits, left after a partial first row.
        write_reg(REG_IMG_WIDTH, 16'(DEF_MAX_WIDTH));
        write_reg(REG_IMG_HEIGHT, 16'(DEF_MAX_HEIGHT));
        send_random(40);
        settle();

        // Tallest setting: 8191 in the height register acts as the maximum.
        // Twenty rows of a three pixel frame give a window on every row from
        // the third, and none of them may be marked as the frame's last.
        write_reg(REG_IMG_WIDTH, 16'd3);
        write_reg(REG_IMG_HEIGHT, 16'hFFFF);
        send_random(60);
        settle();

        // Two 8 x 6 frames offered back to back; the long output stall begins with them.
        write_reg(REG_IMG_WIDTH, 16'd8);
        write_reg(REG_IMG_HEIGHT, 16'd6);
        cur_w   = 8;
        cur_h   = 6;
        hold_go = 1'b1;
        send_random(2 * cur_w * cur_h);
        random_sent += 2 * cur_w * cur_h;

        // Random small frames. Most phases are whole frames; some end with a
        // broken frame that the next register write cuts off, and some get a
        // write to an unused index in their middle.
        while (random_sent < RANDOM_PIXELS) begin
            settle();
            burst = ($urandom_range(0, 3) == 0);
            w_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MIN_DIM - 1)
                                               : $urandom_range(MIN_DIM, 10);
            h_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MIN_DIM - 1)
                                               : $urandom_range(MIN_DIM, 6);
            wrote = 1'b0;
            if ($urandom_range(0, 3) != 0) begin
                wr_data = CFG_DATA_W'($urandom);
                wr_data[IMG_WIDTH_W-1:0] = IMG_WIDTH_W'(w_raw);
                write_reg(REG_IMG_WIDTH, wr_data);
                cur_w = (w_raw < MIN_DIM) ? MIN_DIM : w_raw;
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 3) != 0) begin
                wr_data = CFG_DATA_W'($urandom);
                wr_data[IMG_HEIGHT_W-1:0] = IMG_HEIGHT_W'(h_raw);
                write_reg(REG_IMG_HEIGHT, wr_data);
                cur_h = (h_raw < MIN_DIM) ? MIN_DIM : h_raw;
            end
            total = $urandom_range(1, 3) * cur_w * cur_h;
            if ($urandom_range(0, 4) == 0) begin
                total += $urandom_range(1, cur_w * cur_h - 1);
            end
            if ($urandom_range(0, 5) == 0) begin
                split = $urandom_range(1, total - 1);
                send_random(split);
                settle();
                junk_idx = CFG_IDX_W'($urandom_range(REG_IMG_HEIGHT + 1, 2 ** CFG_IDX_W - 1));
                write_reg(junk_idx, CFG_DATA_W'($urandom));
                random_sent += split;
                total -= split;
            end
            send_random(total);
            random_sent += total;
        end

        settle();
        @(negedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Sent %0d pixel words and %0d register writes; checked %0d blurred words.",
                 pixels_sent, reg_writes, words);
        $display("Frames closed %0d times over sizes from 3x3 to 10x6; output held off once for %0d cycles.",
                 frames, HOLD_CYCLES);
        if (errors == 0) begin
            $display("[rgb_gaussian_blur_3x3_unit] OK");
        end else begin
            $display("%0d mismatches.", errors);
            $display("[rgb_gaussian_blur_3x3_unit] ERROR");
        end
        $finish;
    end

endmodule
